// ===== rtl/core/rlbe_pkg.sv =====
// rlbe_pkg: payload structs, command type and constants of the run-length byte encoder
// no dependencies
`default_nettype none

package rlbe_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [7:0]        t_len;
    typedef logic [2:0]        t_cnt;

    // one raw byte of the block
    typedef struct packed {
        t_byte in_byte;
        logic  in_last;
    } t_in;

    // one encoded output word
    typedef struct packed {
        t_byte out_byte0;
        t_byte out_byte1;
        t_byte out_byte2;
        t_byte out_byte3;
        t_cnt  out_count;
        logic  run_end;
        logic  block_end;
    } t_out;

    // command from the classifier to the word builder
    // pair: two-byte run (repeat or lone final byte); literal: buffered run
    typedef struct packed {
        logic              is_lit;
        t_byte             hdr;
        t_byte             data;
        logic              blk;
        t_len              len;
        logic [WORD_W-1:0] tail;
    } t_cmd;

    localparam t_cnt CNT_PAIR = 3'd2;
    localparam t_cnt CNT_FULL = 3'd4;

    function automatic t_cmd make_pair(input t_byte hdr, input t_byte data, input logic blk);
        t_cmd c;
        c        = '0;
        c.is_lit = 1'b0;
        c.hdr    = hdr;
        c.data   = data;
        c.blk    = blk;
        return c;
    endfunction

    function automatic t_cmd make_lit(input t_len len, input logic [WORD_W-1:0] tail);
        t_cmd c;
        c        = '0;
        c.is_lit = 1'b1;
        c.hdr    = len - 8'd1;
        c.len    = len;
        c.tail   = tail;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/run_length_byte_encoder.sv =====
// run_length_byte_encoder: top level of the PackBits-style byte run-length encoder
// depends on rlbe_pkg, rlbe_front, rlbe_cmd_fifo, rlbe_back, rlbe_ram
//
// usage
//   input channel: one raw byte per transfer (i_in_data), in_last on the final byte of a block
//   output channel: one encoded word per transfer, up to four bytes, out_count says how many;
//   run_end flags the last word of a run, block_end the last word of the block
//   runs: repeat runs (header 1-k, byte) and literal runs (header k-1, bytes), both capped at
//   MAX_RUN; the final byte of a block is sent on its own as a one-byte literal unless it
//   closes an equal pair
// output path
//   a two-byte run word passes the pending command slot, the command queue and the output
//   register; a literal run of k bytes takes ceil((k+1)/4) words, each taken through a read
//   state and a put state into the output register
// throughput
//   a byte that closes no run is taken every cycle while no command waits; a byte that
//   closes one or two runs holds input until its commands are queued; after a literal run is
//   closed, input is held until its last word is in the output register (one read port)
// reset (synchronous, active low)
//   clears run state, pending commands, command queue, builder state and output valid
// stalls
//   a stalled receiver fills the output register, then the command queue, then holds input
`default_nettype none

module run_length_byte_encoder import rlbe_pkg::*; #(
    parameter int MAX_RUN = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    // literal store: 4-byte words, laid out as they leave the block (header slot first)
    localparam int RAM_DEPTH = MAX_RUN/4 + 1;
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    // front to queue
    logic              push;
    t_cmd              push_cmd;
    logic              q_full;
    // queue to back
    logic              pop;
    logic              q_empty;
    t_cmd              q_cmd;
    // literal store ports
    logic              wr_en;
    logic [RAM_AW-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    // back tells front the store is free again
    logic              lit_done;

    // classifier: keeps the open run, writes literal bytes, issues run commands
    rlbe_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .i_q_full   (q_full),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .i_lit_done (lit_done)
    );

    // short command queue so front and back stall on their own
    rlbe_cmd_fifo u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_empty    (q_empty),
        .o_pop_cmd  (q_cmd)
    );

    rlbe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_lit_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // word builder with the output register
    rlbe_back #(
        .MAX_RUN (MAX_RUN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_cmd     (q_cmd),
        .o_pop       (pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_lit_done  (lit_done)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rlbe_ram.sv =====
// rlbe_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module rlbe_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 33,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rlbe_cmd_fifo.sv =====
// rlbe_cmd_fifo: short command queue between classifier and word builder
// depends on rlbe_pkg
`default_nettype none

module rlbe_cmd_fifo import rlbe_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_pop_cmd
);

    t_cmd              r_slots [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full    = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_empty   = (r_count == '0);
    assign o_pop_cmd = r_slots[r_rd_ptr];
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ===== rtl/core/rlbe_front.sv =====
// rlbe_front: takes raw bytes, tracks the open run and issues run commands
// depends on rlbe_pkg; writes literal bytes into the literal word store
`default_nettype none

module rlbe_front import rlbe_pkg::*; #(
    parameter  int MAX_RUN   = 128,
    localparam int RAM_DEPTH = MAX_RUN/4 + 1,
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in_data,
    output logic                   o_push,
    output t_cmd                   o_push_cmd,
    input  wire logic              i_q_full,
    output logic                   o_wr_en,
    output logic [RAM_AW-1:0]      o_wr_addr,
    output logic [WORD_W-1:0]      o_wr_data,
    input  wire logic              i_lit_done
);

    localparam t_len MAX_LEN = t_len'(MAX_RUN);

    t_byte             r_held,  n_held;
    t_len              r_len,   n_len;
    logic              r_rep,   n_rep;
    logic              r_pos,   n_pos;
    logic [WORD_W-1:0] r_asm,   n_asm;
    t_cmd              r_pend0, n_pend0;
    t_cmd              r_pend1, n_pend1;
    logic              r_pv0,   n_pv0;
    logic              r_pv1,   n_pv1;
    logic              r_lit_busy, n_lit_busy;

    logic   accept;
    t_byte  b;
    logic   last;
    t_len   p;
    t_cmd   c0, c1;
    logic   c0v, c1v;
    logic   lit_set;

    assign o_in_ready = !r_pv0 && !r_lit_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_data.in_byte;
    assign last       = i_in_data.in_last;
    assign p          = r_len + 8'd1;
    assign o_push     = r_pv0 && !i_q_full;
    assign o_push_cmd = r_pend0;

    always_comb begin
        n_held    = r_held;
        n_len     = r_len;
        n_rep     = r_rep;
        n_pos     = r_pos;
        n_asm     = r_asm;
        c0        = '0;
        c1        = '0;
        c0v       = 1'b0;
        c1v       = 1'b0;
        lit_set   = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = RAM_AW'(p >> 2);
        o_wr_data = {r_held, r_asm[23:0]};
        if (accept) begin
            if (!r_pos) begin
                if (last) begin
                    c0v = 1'b1;
                    c0  = make_pair(8'd0, b, 1'b1);
                end else begin
                    n_held = b;
                    n_pos  = 1'b1;
                    n_rep  = 1'b0;
                    n_len  = '0;
                end
            end else if (r_rep) begin
                if (b == r_held && r_len < MAX_LEN && !last) begin
                    n_len = r_len + 8'd1;
                end else begin
                    c0v   = 1'b1;
                    c0    = make_pair(8'd1 - r_len, r_held, 1'b0);
                    n_rep = 1'b0;
                    n_len = '0;
                    if (last) begin
                        c1v    = 1'b1;
                        c1     = make_pair(8'd0, b, 1'b1);
                        n_pos  = 1'b0;
                        n_held = '0;
                    end else begin
                        n_held = b;
                    end
                end
            end else if (b != r_held) begin
                // held byte joins the literal run at stream position len+1
                n_asm[{p[1:0], 3'b000} +: 8] = r_held;
                if (p[1:0] == 2'd3) begin
                    o_wr_en = 1'b1;
                end
                n_len  = p;
                n_held = b;
                if (p == MAX_LEN || last) begin
                    c0v     = 1'b1;
                    c0      = make_lit(p, n_asm);
                    lit_set = 1'b1;
                    n_len   = '0;
                end
                if (last) begin
                    c1v    = 1'b1;
                    c1     = make_pair(8'd0, b, 1'b1);
                    n_pos  = 1'b0;
                    n_held = '0;
                end
            end else begin
                // equal pair closes any literal and opens a repeat, or ends the block as a repeat pair
                if (r_len != '0) begin
                    c0v     = 1'b1;
                    c0      = make_lit(r_len, r_asm);
                    lit_set = 1'b1;
                end
                if (last) begin
                    c1v    = 1'b1;
                    c1     = make_pair(8'hFF, b, 1'b1);
                    n_pos  = 1'b0;
                    n_rep  = 1'b0;
                    n_len  = '0;
                    n_held = '0;
                end else begin
                    n_rep  = 1'b1;
                    n_len  = 8'd2;
                    n_held = b;
                end
            end
        end
    end

    // pending command pair, oldest in slot 0
    always_comb begin
        n_pend0 = r_pend0;
        n_pend1 = r_pend1;
        n_pv0   = r_pv0;
        n_pv1   = r_pv1;
        if (accept) begin
            n_pv0   = c0v || c1v;
            n_pend0 = c0v ? c0 : c1;
            n_pv1   = c0v && c1v;
            n_pend1 = c1;
        end else if (o_push) begin
            n_pend0 = r_pend1;
            n_pv0   = r_pv1;
            n_pv1   = 1'b0;
        end
        n_lit_busy = (r_lit_busy && !i_lit_done) || lit_set;
    end

    always_ff @(posedge i_clk) begin
        r_asm   <= n_asm;
        r_pend0 <= n_pend0;
        r_pend1 <= n_pend1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_len      <= '0;
            r_rep      <= 1'b0;
            r_pos      <= 1'b0;
            r_pv0      <= 1'b0;
            r_pv1      <= 1'b0;
            r_lit_busy <= 1'b0;
        end else begin
            r_held     <= n_held;
            r_len      <= n_len;
            r_rep      <= n_rep;
            r_pos      <= n_pos;
            r_pv0      <= n_pv0;
            r_pv1      <= n_pv1;
            r_lit_busy <= n_lit_busy;
        end
    end

    a_rep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep |-> (r_len >= 8'd2 && r_len <= MAX_LEN))
        else $error("repeat run length out of range");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pos |-> (!r_rep && r_len == '0))
        else $error("run state left over at block start");

    a_pend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv1 |-> r_pv0)
        else $error("second pending command without first");

endmodule

`default_nettype wire

// ===== rtl/core/rlbe_back.sv =====
// rlbe_back: turns run commands into 4-byte output words
// depends on rlbe_pkg; reads literal words from the literal word store
`default_nettype none

module rlbe_back import rlbe_pkg::*; #(
    parameter  int MAX_RUN   = 128,
    localparam int RAM_DEPTH = MAX_RUN/4 + 1,
    localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_empty,
    input  wire t_cmd              i_q_cmd,
    output logic                   o_pop,
    output logic                   o_rd_en,
    output logic [RAM_AW-1:0]      o_rd_addr,
    input  wire logic [WORD_W-1:0] i_rd_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out_data,
    output logic                   o_lit_done
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_PUT  = 2'd2;

    logic [1:0]        r_state, n_state;
    t_cmd              r_cmd,   n_cmd;
    logic [RAM_AW-1:0] r_word,  n_word;
    logic              r_ovalid, n_ovalid;
    t_out              r_out,   n_out;

    logic              ld_ok;
    logic              load;
    logic [RAM_AW-1:0] last_idx;
    logic              is_last;
    logic              from_tail;
    logic [WORD_W-1:0] src;
    t_cnt              cnt;
    t_out              lit_word;

    assign ld_ok     = !r_ovalid || i_out_ready;
    assign last_idx  = RAM_AW'(r_cmd.len >> 2);
    assign is_last   = (r_word == last_idx);
    // last word comes from the tail unless the run fills it exactly
    assign from_tail = is_last && (r_cmd.len[1:0] != 2'd3);
    assign src       = from_tail ? r_cmd.tail : i_rd_data;
    assign cnt       = is_last ? ({1'b0, r_cmd.len[1:0]} + 3'd1) : CNT_FULL;
    assign o_rd_addr = r_word;

    always_comb begin
        lit_word.out_byte0 = (r_word == '0) ? r_cmd.hdr : src[7:0];
        lit_word.out_byte1 = (cnt > 3'd1) ? src[15:8]  : '0;
        lit_word.out_byte2 = (cnt > 3'd2) ? src[23:16] : '0;
        lit_word.out_byte3 = (cnt > 3'd3) ? src[31:24] : '0;
        lit_word.out_count = cnt;
        lit_word.run_end   = is_last;
        lit_word.block_end = 1'b0;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_word     = r_word;
        n_out      = r_out;
        load       = 1'b0;
        o_pop      = 1'b0;
        o_rd_en    = 1'b0;
        o_lit_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_cmd.is_lit) begin
                        o_pop   = 1'b1;
                        n_cmd   = i_q_cmd;
                        n_word  = '0;
                        n_state = S_READ;
                    end else if (ld_ok) begin
                        o_pop           = 1'b1;
                        load            = 1'b1;
                        n_out.out_byte0 = i_q_cmd.hdr;
                        n_out.out_byte1 = i_q_cmd.data;
                        n_out.out_byte2 = '0;
                        n_out.out_byte3 = '0;
                        n_out.out_count = CNT_PAIR;
                        n_out.run_end   = 1'b1;
                        n_out.block_end = i_q_cmd.blk;
                    end
                end
            end
            S_READ: begin
                o_rd_en = 1'b1;
                n_state = S_PUT;
            end
            S_PUT: begin
                if (ld_ok) begin
                    load  = 1'b1;
                    n_out = lit_word;
                    if (is_last) begin
                        o_lit_done = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ovalid = load || (r_ovalid && !i_out_ready);
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_busy_is_literal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> r_cmd.is_lit)
        else $error("word builder busy on a non-literal command");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_out.out_count >= 3'd1 && r_out.out_count <= CNT_FULL))
        else $error("output word byte count out of range");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for run_length_byte_encoder, raw byte blocks in, encoded
// words checked against a PackBits word predictor held in a small scoreboard class
// depends on rlbe_pkg and the encoder rtl under rtl/core

module testbench;
    import rlbe_pkg::*;

    localparam int    MAX_RUN      = 128;
    localparam int    ITEM_TARGET  = 410;
    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    LONG_HOLD    = 400;
    localparam int    TAIL_CYCLES  = 20;
    localparam t_byte LONE_HDR     = 8'h00;   // header of a one-byte literal run

    // predictor of the encoded word stream plus the queue of words still owed
    class rle_word_tracker;
        t_byte       lit_bytes [MAX_RUN];
        t_byte       held;
        int unsigned run_len;
        bit          in_repeat;
        bit          have_held;
        t_out        expected_words [$];
        int unsigned errors;

        function void clear_block();
            have_held = 1'b0;
            in_repeat = 1'b0;
            run_len   = 0;
            held      = '0;
        endfunction

        // split one encoded run into words of up to four bytes
        function void push_run(input t_byte bytes [$], input bit final_run);
            t_out        w;
            int unsigned cnt;
            for (int off = 0; off < bytes.size(); off += 4) begin
                cnt = bytes.size() - off;
                if (cnt > 4)
                    cnt = 4;
                w           = '0;
                w.out_byte0 = bytes[off];
                if (cnt > 1) w.out_byte1 = bytes[off + 1];
                if (cnt > 2) w.out_byte2 = bytes[off + 2];
                if (cnt > 3) w.out_byte3 = bytes[off + 3];
                w.out_count = t_cnt'(cnt);
                w.run_end   = (off + cnt >= bytes.size());
                w.block_end = final_run && w.run_end;
                expected_words.push_back(w);
            end
        endfunction

        function void push_pair(input t_byte hdr, input t_byte data, input bit final_run);
            t_byte bytes [$];
            bytes.push_back(hdr);
            bytes.push_back(data);
            push_run(bytes, final_run);
        endfunction

        function void flush_literal();
            t_byte bytes [$];
            if (run_len == 0)
                return;
            bytes.push_back(t_byte'(run_len - 1));
            for (int i = 0; i < run_len; i++)
                bytes.push_back(lit_bytes[i]);
            run_len = 0;
            push_run(bytes, 1'b0);
        endfunction

        // one accepted input transfer
        function void note_byte(input t_in item);
            t_byte b;
            bit    last;
            b    = item.in_byte;
            last = item.in_last;
            if (!have_held) begin
                if (last) begin
                    push_pair(LONE_HDR, b, 1'b1);
                    clear_block();
                end else begin
                    held      = b;
                    have_held = 1'b1;
                    in_repeat = 1'b0;
                    run_len   = 0;
                end
            end else if (in_repeat) begin
                if (b == held && run_len < MAX_RUN && !last) begin
                    run_len++;
                end else begin
                    push_pair(t_byte'(1 - int'(run_len)), held, 1'b0);
                    in_repeat = 1'b0;
                    run_len   = 0;
                    if (last) begin
                        push_pair(LONE_HDR, b, 1'b1);
                        clear_block();
                    end else begin
                        held = b;
                    end
                end
            end else if (held != b) begin
                lit_bytes[run_len] = held;
                run_len++;
                if (run_len >= MAX_RUN)
                    flush_literal();
                held = b;
                if (last) begin
                    flush_literal();
                    push_pair(LONE_HDR, b, 1'b1);
                    clear_block();
                end
            end else begin
                flush_literal();
                if (last) begin
                    push_pair(t_byte'(1 - 2), b, 1'b1);
                    clear_block();
                end else begin
                    in_repeat = 1'b1;
                    run_len   = 2;
                    held      = b;
                end
            end
        endfunction

        function void match_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        // one accepted output transfer
        function void check_word(input t_out got);
            t_out want;
            if (expected_words.size() == 0) begin
                errors++;
                $display("%0t: word expected none, got %h", $time, got);
                return;
            end
            want = expected_words.pop_front();
            match_field("out_byte0", want.out_byte0, got.out_byte0);
            match_field("out_byte1", want.out_byte1, got.out_byte1);
            match_field("out_byte2", want.out_byte2, got.out_byte2);
            match_field("out_byte3", want.out_byte3, got.out_byte3);
            match_field("out_count", 8'(want.out_count), 8'(got.out_count));
            match_field("run_end",   8'(want.run_end),   8'(got.run_end));
            match_field("block_end", 8'(want.block_end), 8'(got.block_end));
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    rle_word_tracker tracker = new();

    // sender bookkeeping
    t_byte       block_q [$];      // bytes of the block about to be sent
    int unsigned burst_left  = 0;
    int unsigned items_sent  = 0;
    // long receiver hold-offs: asked by the stimulus, served by the receiver
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;
    int unsigned rx_hold_left = 0;
    logic [7:0]  rx_step     = '0;
    int unsigned cycle_count = 0;

    run_length_byte_encoder #(
        .MAX_RUN     (MAX_RUN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // run limit in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: a long hold-off when asked, otherwise a cycling stall pattern
    // of steady, coin-flip, sparse and periodic phases
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= 0;
        end else if (rx_hold_left != 0) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (holds_done != holds_asked) begin
            i_out_ready  <= 1'b0;
            holds_done   <= holds_done + 1;
            rx_hold_left <= LONG_HOLD;
        end else begin
            rx_step <= rx_step + 8'd1;
            case (rx_step[7:6])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= 1'($urandom_range(0, 1));
                2'd2:    i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= (rx_step[2:0] != 3'd0);
            endcase
        end
    end

    // output transfers are checked on the edge that accepts them
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_word(o_out_data);
    end

    // one input transfer; bursts of random length, mostly separated by random gaps,
    // and valid stays high straight into the next transfer inside a burst
    task automatic send_byte(input t_byte b, input bit last);
        t_in item;
        item.in_byte = b;
        item.in_last = last;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_byte(item);
        items_sent++;
    endtask

    // in_last goes on the final byte of the queued block
    task automatic send_block();
        for (int i = 0; i < block_q.size(); i++)
            send_byte(block_q[i], i == block_q.size() - 1);
    endtask

    // sender stops until every owed word has come back
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.expected_words.size() != 0);
    endtask

    // runs of equal bytes mixed with single bytes, from a narrow or the full byte range
    function automatic void fill_mixed(input int unsigned n);
        bit          narrow;
        t_byte       v;
        int unsigned seg;
        block_q.delete();
        narrow = 1'($urandom_range(0, 1));
        while (block_q.size() < n) begin
            if (narrow) begin
                case ($urandom_range(0, 3))
                    0:       v = 8'h00;
                    1:       v = 8'hFF;
                    2:       v = 8'h80;
                    default: v = 8'h7F;
                endcase
            end else begin
                v = t_byte'($urandom_range(0, 255));
            end
            seg = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 7) : 1;
            repeat (seg)
                if (block_q.size() < n)
                    block_q.push_back(v);
        end
    endfunction

    // every byte differs from its neighbour, so the literal cap is reached
    function automatic void fill_literal(input int unsigned n);
        t_byte v;
        block_q.delete();
        v = t_byte'($urandom_range(0, 255));
        repeat (n) begin
            block_q.push_back(v);
            v = v + t_byte'($urandom_range(1, 255));
        end
    endfunction

    // n-1 copies of one value, then a random final byte
    function automatic void fill_repeat(input int unsigned n);
        t_byte v;
        block_q.delete();
        v = t_byte'($urandom_range(0, 255));
        repeat (n - 1) block_q.push_back(v);
        block_q.push_back(t_byte'($urandom_range(0, 255)));
    endfunction

    initial begin
        bit          mid_pause_done;
        int unsigned n;
        mid_pause_done = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed blocks
        // one-byte blocks at both byte extremes
        block_q = '{8'h00};
        send_block();
        block_q = '{8'hFF};
        send_block();
        // two equal final bytes close as one repeat pair
        block_q = '{8'hA5, 8'hA5};
        send_block();
        // two unequal bytes: a one-byte literal, then the lone final byte
        block_q = '{8'h01, 8'h80};
        send_block();
        // repeat run broken by a different final byte
        block_q = '{8'h7E, 8'h7E, 8'h7E, 8'h7E, 8'h3C};
        send_block();
        // literal run followed by an equal pair at the block end
        block_q = '{8'h10, 8'h20, 8'h30, 8'h30};
        send_block();
        // open repeat stops before an equal final byte
        block_q = '{8'h55, 8'h55, 8'h55};
        send_block();
        // literal turning into a repeat mid-block
        block_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
        send_block();
        drain_outputs();

        // long receiver hold-off while a capped literal run is offered, so the
        // output word and then the input back up
        holds_asked <= holds_asked + 1;
        fill_literal($urandom_range(129, 134));
        send_block();
        drain_outputs();
        // repeat run at or past the cap
        fill_repeat($urandom_range(129, 140));
        send_block();

        // random blocks, mostly short, a few of one or two bytes
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(1, 2);
            else
                n = $urandom_range(3, 20);
            fill_mixed(n);
            send_block();
            if (!mid_pause_done && items_sent >= 340) begin
                drain_outputs();
                mid_pause_done = 1'b1;
            end
        end

        drain_outputs();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.expected_words.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
